FILE: hdl/lgw_pkg.sv
// shared widths, constants, reciprocal table and rounding helpers for the legendre block
package lgw_pkg;

  localparam int MAX_ORDER_DEF = 32;

  localparam int X_W      = 32;
  localparam int ORDER_W  = 6;
  localparam int MUL_W    = 34;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int P_W      = 34;
  localparam int NUM_W    = 40;
  localparam int NUM_SPLIT = 20;
  localparam int RCP_W    = 25;
  localparam int RCP_FRAC = 25;
  localparam int Q30_FRAC = 30;
  localparam int SQ_W     = 33;
  localparam int QUO_W    = 32;
  localparam int DIVD_W   = 62;
  localparam int ROM_DEPTH = 65;

  localparam logic [ORDER_W-1:0] ORDER_RST = 6'd4;
  localparam logic signed [X_W-1:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic [QUO_W-1:0] WEIGHT_SAT = 32'hFFFF_FFFF;

  localparam logic signed [PROD_W-1:0] NUM_LIM = 68'sd274877906944;
  localparam logic signed [PROD_W-1:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [PROD_W-1:0] S32_MIN = -68'sd2147483648;

  // round(2^25 / n), entries below two unused
  localparam logic [RCP_W-1:0] RECIP_ROM [ROM_DEPTH] = '{
    25'd0,        25'd0,        25'd16777216, 25'd11184811, 25'd8388608,
    25'd6710886,  25'd5592405,  25'd4793490,  25'd4194304,  25'd3728270,
    25'd3355443,  25'd3050403,  25'd2796203,  25'd2581110,  25'd2396745,
    25'd2236962,  25'd2097152,  25'd1973790,  25'd1864135,  25'd1766023,
    25'd1677722,  25'd1597830,  25'd1525201,  25'd1458888,  25'd1398101,
    25'd1342177,  25'd1290555,  25'd1242757,  25'd1198373,  25'd1157049,
    25'd1118481,  25'd1082401,  25'd1048576,  25'd1016801,  25'd986895,
    25'd958698,   25'd932068,   25'd906877,   25'd883011,   25'd860370,
    25'd838861,   25'd818401,   25'd798915,   25'd780336,   25'd762601,
    25'd745654,   25'd729444,   25'd713924,   25'd699051,   25'd684784,
    25'd671089,   25'd657930,   25'd645278,   25'd633102,   25'd621378,
    25'd610081,   25'd599186,   25'd588674,   25'd578525,   25'd568719,
    25'd559241,   25'd550073,   25'd541201,   25'd532610,   25'd524288
  };

  // arithmetic shift right, round half away from zero
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                       input int unsigned sh);
    logic signed [PROD_W-1:0] half;
    half = '0;
    half[sh-1] = 1'b1;
    if (v[PROD_W-1]) begin
      return (v + half - PROD_W'(1)) >>> sh;
    end else begin
      return (v + half) >>> sh;
    end
  endfunction

  function automatic logic signed [X_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > S32_MAX) begin
      return X_W'(S32_MAX);
    end else if (v < S32_MIN) begin
      return X_W'(S32_MIN);
    end else begin
      return X_W'(v);
    end
  endfunction

endpackage

FILE: hdl/legendre_value_and_gll_weight.sv
// legendre polynomial value and lobatto weight on one shared multiplier and a serial divider
//
// One abscissa (signed Q2.30) is taken per item and one result comes back: P_Q(x) in signed
// Q2.30, the weight 2/(Q(Q+1)P^2) in unsigned Q2.30, and a saturation flag in m_tuser. Q is
// poly_order, limited to MAX_ORDER. The block works on one item at a time and s_tready is low
// while it does. For Q of two or more it runs one recursion step per n from two to Q, each through
// S_XL to S_L with its products on the single 34x34 multiplier plus rounding and clamping; for
// smaller Q the recursion is skipped. The weight setup runs S_QQ to S_DCHK, the restoring divider
// then yields one quotient bit per cycle until the quotient is complete, and S_OUT loads the
// output register before the return to idle; a zero divisor or an overflowing quotient skips the
// divider and saturates the weight. A finished result waits in the output register while the next
// item is already accepted; a result that is still not taken holds the next one in its last step.
module legendre_value_and_gll_weight #(
  parameter int MAX_ORDER = lgw_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lgw_pkg::ORDER_W-1:0] cfg_wr_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,    // abscissa
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,    // poly_value, quad_weight
  output logic                        m_tuser     // weight_saturated
);

  localparam int N_W   = $clog2(MAX_ORDER + 1);
  localparam int QQ_W  = 2 * N_W;
  localparam int D_W   = QQ_W + lgw_pkg::SQ_W;
  localparam int DSH_W = D_W + lgw_pkg::QUO_W - 1;
  localparam int CNT_W = $clog2(lgw_pkg::QUO_W);
  localparam int ROM_A_W = $clog2(lgw_pkg::ROM_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_XL, S_P, S_A, S_B, S_C, S_LO, S_HI, S_L,
    S_QQ, S_SQ, S_SR, S_D, S_DCHK, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic [lgw_pkg::ORDER_W-1:0]           poly_order;
  logic [N_W-1:0]                        q;
  logic [N_W-1:0]                        n;
  logic signed [lgw_pkg::X_W-1:0]        x;
  logic signed [lgw_pkg::X_W-1:0]        l1;
  logic signed [lgw_pkg::X_W-1:0]        l2;
  logic signed [lgw_pkg::P_W-1:0]        p;
  logic signed [lgw_pkg::NUM_W-1:0]      num;
  logic signed [lgw_pkg::PROD_W-1:0]     prod;
  logic signed [lgw_pkg::PROD_W-1:0]     acc;
  logic [QQ_W-1:0]                       qq;
  logic [lgw_pkg::SQ_W-1:0]              sq;
  logic [lgw_pkg::DIVD_W-1:0]            rem;
  logic [DSH_W-1:0]                      dsh;
  logic [lgw_pkg::QUO_W-1:0]             quo;
  logic [CNT_W-1:0]                      cnt;
  logic [lgw_pkg::QUO_W-1:0]             weight;
  logic                                  wsat;

  logic signed [lgw_pkg::MUL_W-1:0]      mul_a;
  logic signed [lgw_pkg::MUL_W-1:0]      mul_b;
  logic [lgw_pkg::RCP_W-1:0]             recip;
  logic signed [lgw_pkg::PROD_W-1:0]     diff;
  logic signed [lgw_pkg::PROD_W-1:0]     step_sum;
  logic [D_W-1:0]                        d;
  logic [lgw_pkg::DIVD_W-1:0]            dividend;
  logic                                  div_ge;
  logic [lgw_pkg::QUO_W-1:0]             quo_next;

  always_comb begin
    if (int'(poly_order) > MAX_ORDER) begin
      q = N_W'(MAX_ORDER);
    end else begin
      q = N_W'(poly_order);
    end
  end

  assign recip    = lgw_pkg::RECIP_ROM[ROM_A_W'(n)];
  assign diff     = acc - prod;
  assign step_sum = (prod <<< lgw_pkg::NUM_SPLIT) + acc;
  assign d        = prod[D_W-1:0];
  assign dividend = (lgw_pkg::DIVD_W'(1) << (lgw_pkg::DIVD_W - 1)) + lgw_pkg::DIVD_W'(d >> 1);
  assign div_ge   = DSH_W'(rem) >= dsh;
  assign quo_next = {quo[lgw_pkg::QUO_W-2:0], div_ge};
  assign s_tready = (state == S_IDLE);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_XL: begin
        mul_a = lgw_pkg::MUL_W'(x);
        mul_b = lgw_pkg::MUL_W'(l1);
      end
      S_A: begin
        mul_a = p;
        mul_b = lgw_pkg::MUL_W'({n, 1'b0}) - lgw_pkg::MUL_W'(1);
      end
      S_B: begin
        mul_a = lgw_pkg::MUL_W'(l2);
        mul_b = lgw_pkg::MUL_W'(n) - lgw_pkg::MUL_W'(1);
      end
      S_LO: begin
        mul_a = lgw_pkg::MUL_W'(num[lgw_pkg::NUM_SPLIT-1:0]);
        mul_b = lgw_pkg::MUL_W'(recip);
      end
      S_HI: begin
        mul_a = lgw_pkg::MUL_W'($signed(num[lgw_pkg::NUM_W-1:lgw_pkg::NUM_SPLIT]));
        mul_b = lgw_pkg::MUL_W'(recip);
      end
      S_QQ: begin
        mul_a = lgw_pkg::MUL_W'(q);
        mul_b = lgw_pkg::MUL_W'(q) + lgw_pkg::MUL_W'(1);
      end
      S_SQ: begin
        mul_a = lgw_pkg::MUL_W'(l1);
        mul_b = lgw_pkg::MUL_W'(l1);
      end
      S_D: begin
        mul_a = lgw_pkg::MUL_W'(qq);
        mul_b = lgw_pkg::MUL_W'(sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state      <= S_IDLE;
      poly_order <= lgw_pkg::ORDER_RST;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        poly_order <= cfg_wr_data;
      end
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            x  <= $signed(s_tdata);
            l2 <= lgw_pkg::ONE_Q30;
            l1 <= (q == '0) ? lgw_pkg::ONE_Q30 : $signed(s_tdata);
            n  <= N_W'(2);
            state <= (q >= N_W'(2)) ? S_XL : S_QQ;
          end
        end
        S_XL: state <= S_P;
        S_P: begin
          p     <= lgw_pkg::P_W'(lgw_pkg::rnd_shr(prod, lgw_pkg::Q30_FRAC));
          state <= S_A;
        end
        S_A: state <= S_B;
        S_B: begin
          acc   <= prod;
          state <= S_C;
        end
        S_C: begin
          if (diff > lgw_pkg::NUM_LIM) begin
            num <= lgw_pkg::NUM_W'(lgw_pkg::NUM_LIM);
          end else if (diff < -lgw_pkg::NUM_LIM) begin
            num <= lgw_pkg::NUM_W'(-lgw_pkg::NUM_LIM);
          end else begin
            num <= lgw_pkg::NUM_W'(diff);
          end
          state <= S_LO;
        end
        S_LO: state <= S_HI;
        S_HI: begin
          acc   <= prod;
          state <= S_L;
        end
        S_L: begin
          l2 <= l1;
          l1 <= lgw_pkg::sat32(lgw_pkg::rnd_shr(step_sum, lgw_pkg::RCP_FRAC));
          if (n == q) begin
            state <= S_QQ;
          end else begin
            n     <= n + N_W'(1);
            state <= S_XL;
          end
        end
        S_QQ: state <= S_SQ;
        S_SQ: begin
          qq    <= prod[QQ_W-1:0];
          state <= S_SR;
        end
        S_SR: begin
          sq    <= lgw_pkg::SQ_W'(lgw_pkg::rnd_shr(prod, lgw_pkg::Q30_FRAC));
          state <= S_D;
        end
        S_D: state <= S_DCHK;
        S_DCHK: begin
          if (d == '0 || (D_W + lgw_pkg::QUO_W)'(dividend) >= {d, lgw_pkg::QUO_W'(0)}) begin
            weight <= lgw_pkg::WEIGHT_SAT;
            wsat   <= 1'b1;
            state  <= S_OUT;
          end else begin
            rem   <= dividend;
            dsh   <= {d, (lgw_pkg::QUO_W - 1)'(0)};
            quo   <= '0;
            cnt   <= CNT_W'(lgw_pkg::QUO_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem <= rem - lgw_pkg::DIVD_W'(dsh);
          end
          dsh <= dsh >> 1;
          quo <= quo_next;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            weight <= quo_next;
            wsat   <= 1'b0;
            state  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {weight, l1};
            m_tuser  <= wsat;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/tb_legendre_value_and_gll_weight.sv
// self-checking testbench for the legendre value and lobatto weight stream block
`timescale 1ns / 100ps

module tb_legendre_value_and_gll_weight;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 103;

  typedef struct packed {
    logic signed [31:0] poly_value;
    logic [31:0]        quad_weight;
    logic               weight_saturated;
  } lgw_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [lgw_pkg::ORDER_W-1:0] cfg_wr_data = '0;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [31:0]                 s_tdata = '0;   // abscissa
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [63:0]                 m_tdata;        // poly_value, quad_weight
  logic                        m_tuser;        // weight_saturated

  logic [31:0]                 abscissa_queue[$];
  lgw_result_t                 results_due[$];
  logic [lgw_pkg::ORDER_W-1:0] order_setting = lgw_pkg::ORDER_RST;
  logic                        send_calm = 1'b0;
  logic                        recv_calm = 1'b0;
  int                          sender_gap = 0;
  int                          receiver_stall = 0;
  int                          error_count = 0;
  int                          idle_cycles = 0;

  legendre_value_and_gll_weight dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always #5 clk = ~clk;

  // shift right with round half away from zero
  function automatic longint round_shift(input longint v, input int sh);
    longint half;
    half = 64'sd1 <<< (sh - 1);
    if (v >= 0) begin
      return (v + half) >>> sh;
    end
    return -(((-v) + half) >>> sh);
  endfunction

  function automatic longint clamp_q30(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // bonnet recursion in q2.30 with the reciprocal of n in q0.25
  function automatic logic signed [31:0] legendre_at(input int q, input logic signed [31:0] x);
    longint lm2, lm1, prod, num, rcp, lim;
    int n;
    lim = 64'sd1 <<< 38;
    lm2 = 64'sd1 <<< 30;
    lm1 = longint'(x);
    if (q == 0) begin
      return lgw_pkg::ONE_Q30;
    end
    for (n = 2; n <= q; n++) begin
      prod = round_shift(longint'(x) * lm1, 30);
      num = longint'(2 * n - 1) * prod - longint'(n - 1) * lm2;
      if (num > lim) num = lim;
      if (num < -lim) num = -lim;
      rcp = ((64'sd1 <<< 25) + longint'(n / 2)) / longint'(n);
      lm2 = lm1;
      lm1 = clamp_q30(round_shift(num * rcp, 25));
    end
    return 32'(lm1);
  endfunction

  function automatic lgw_result_t predict_lgw(input logic [31:0] x,
                                              input logic [lgw_pkg::ORDER_W-1:0] order);
    lgw_result_t r;
    int q;
    longint v, sq;
    longint unsigned d, t;
    q = (int'(order) > lgw_pkg::MAX_ORDER_DEF) ? lgw_pkg::MAX_ORDER_DEF : int'(order);
    r.poly_value = legendre_at(q, x);
    v = longint'(r.poly_value);
    sq = round_shift(v * v, 30);
    d = longint'(q * (q + 1)) * sq;
    r.quad_weight = lgw_pkg::WEIGHT_SAT;
    r.weight_saturated = 1'b1;
    if (d != 0) begin
      t = ((64'd1 << 61) + d / 2) / d;
      if (t <= 64'hFFFF_FFFF) begin
        r.quad_weight = 32'(t);
        r.weight_saturated = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] draw_abscissa();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
    end else if (pick < 85) begin
      return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
    end else if (pick < 90) begin
      case ($urandom_range(0, 3))
        0: return 32'h4000_0000;
        1: return 32'hC000_0000;
        2: return 32'h3FFF_FFFF;
        default: return 32'hC000_0001;
      endcase
    end
    return $urandom();
  endfunction

  task automatic report_error(input string what, input logic [31:0] want, input logic [31:0] got);
    if (error_count < 10) begin
      $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
    end
    error_count++;
  endtask

  // sampled at the falling edge so the clocked blocks have settled
  task automatic drain();
    @(negedge clk);
    while (abscissa_queue.size() != 0 || s_tvalid || results_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_order(input logic [lgw_pkg::ORDER_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    order_setting = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender: gap drawn after every accepted item
  always @(posedge clk) begin : drive_abscissa
    int gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      sender_gap <= 0;
    end else begin
      gap = sender_gap;
      if (s_tvalid && s_tready) begin
        results_due.push_back(predict_lgw(s_tdata, order_setting));
        gap = send_calm ? 0 : $urandom_range(0, 5);
      end
      if (!s_tvalid || s_tready) begin
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          sender_gap <= gap - 1;
        end else if (abscissa_queue.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= abscissa_queue.pop_front();
          sender_gap <= 0;
        end else begin
          s_tvalid <= 1'b0;
          sender_gap <= 0;
        end
      end
    end
  end

  // receiver: stall drawn after every accepted item
  always @(posedge clk) begin : check_results
    int stall;
    lgw_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      receiver_stall <= 0;
    end else begin
      stall = receiver_stall;
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          report_error("unexpected item poly_value", 32'h0, m_tdata[31:0]);
        end else begin
          want = results_due.pop_front();
          if (m_tdata[31:0] !== want.poly_value) begin
            report_error("poly_value", want.poly_value, m_tdata[31:0]);
          end
          if (m_tdata[63:32] !== want.quad_weight) begin
            report_error("quad_weight", want.quad_weight, m_tdata[63:32]);
          end
          if (m_tuser !== want.weight_saturated) begin
            report_error("weight_saturated", 32'(want.weight_saturated), 32'(m_tuser));
          end
        end
        stall = recv_calm ? 0 : $urandom_range(0, 5);
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        receiver_stall <= stall - 1;
      end else begin
        m_tready <= 1'b1;
        receiver_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int count;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset order: extremes and exact endpoints
    abscissa_queue.push_back(32'h0000_0000);
    abscissa_queue.push_back(32'h4000_0000);
    abscissa_queue.push_back(32'hC000_0000);
    abscissa_queue.push_back(32'h8000_0000);
    abscissa_queue.push_back(32'h7FFF_FFFF);
    abscissa_queue.push_back(32'h0000_0001);
    abscissa_queue.push_back(32'hFFFF_FFFF);
    abscissa_queue.push_back(32'h2000_0000);

    // order zero: value one, divisor zero
    write_order(6'd0);
    abscissa_queue.push_back(32'h1234_5678);
    abscissa_queue.push_back(32'h8000_0000);

    // order one: zero and tiny values, weight too large
    write_order(6'd1);
    abscissa_queue.push_back(32'h0000_0000);
    abscissa_queue.push_back(32'h0000_0064);
    abscissa_queue.push_back(32'h1000_0000);
    abscissa_queue.push_back(32'h4000_0000);

    // odd order at a root
    write_order(6'd3);
    abscissa_queue.push_back(32'h0000_0000);

    // order above the maximum saturates
    write_order(6'd63);
    abscissa_queue.push_back(32'h4000_0000);
    abscissa_queue.push_back(32'h7FFF_FFFF);
    abscissa_queue.push_back(32'h1A2B_3C4D);

    write_order(6'd32);
    abscissa_queue.push_back(32'hC000_0000);
    abscissa_queue.push_back(32'h0000_0000);

    write_order(6'd2);
    abscissa_queue.push_back(32'h8000_0000);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 3) == 0) begin
        write_order(6'($urandom_range(9, 63)));
      end else begin
        write_order(6'($urandom_range(0, 8)));
      end
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      count = PHASE_ITEMS;
      for (int i = 0; i < count; i++) begin
        if (i == count / 2 && $urandom_range(0, 1) == 1) begin
          drain();
        end
        abscissa_queue.push_back(draw_abscissa());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
